// ===== sv/gfr_pkg.sv =====
package gfr_pkg;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [2:0] CMD_PIXEL  = 3'd0;
  localparam logic [2:0] CMD_CHAR   = 3'd1;
  localparam logic [2:0] CMD_CURSOR = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  localparam int unsigned GLYPH_COLS    = 5;
  localparam int unsigned GLYPH_PITCH   = 6;
  localparam int unsigned GLYPH_COUNT   = 39;
  localparam logic [5:0]  GLYPH_SPACE   = 6'd0;
  localparam logic [5:0]  GLYPH_DIGIT0  = 6'd1;
  localparam logic [5:0]  GLYPH_LETTER  = 6'd11;
  localparam logic [5:0]  GLYPH_PERIOD  = 6'd37;
  localparam logic [5:0]  GLYPH_HYPHEN  = 6'd38;

  // one glyph per entry, column 0 in the low byte
  localparam logic [39:0] FONT [GLYPH_COUNT] = '{
    40'h00_00_00_00_00,
    40'h3E_45_49_51_3E, 40'h00_40_7F_42_00, 40'h46_49_51_61_42, 40'h31_4B_45_41_21,
    40'h10_7F_12_14_18, 40'h39_45_45_45_27, 40'h30_49_49_4A_3C, 40'h03_05_09_71_01,
    40'h36_49_49_49_36, 40'h1E_29_49_49_06,
    40'h7E_11_11_11_7E, 40'h36_49_49_49_7F, 40'h22_41_41_41_3E, 40'h1C_22_41_41_7F,
    40'h41_49_49_49_7F, 40'h01_09_09_09_7F, 40'h7A_49_49_41_3E, 40'h7F_08_08_08_7F,
    40'h00_41_7F_41_00, 40'h01_3F_41_40_20, 40'h41_22_14_08_7F, 40'h40_40_40_40_7F,
    40'h7F_02_0C_02_7F, 40'h7F_10_08_04_7F, 40'h3E_41_41_41_3E, 40'h06_09_09_09_7F,
    40'h5E_21_51_41_3E, 40'h46_29_19_09_7F, 40'h31_49_49_49_46, 40'h01_01_7F_01_01,
    40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F, 40'h63_14_08_14_63,
    40'h07_08_70_08_07, 40'h43_45_49_51_61,
    40'h00_00_60_60_00,
    40'h08_08_08_08_08
  };

  typedef enum logic [1:0] {
    WSEL_PIXEL,
    WSEL_GLYPH,
    WSEL_CLEAR
  } wsel_e;

  typedef struct packed {
    logic  load;
    logic  set_ign;
    logic  rd_en;
    logic  wr_en;
    wsel_e wsel;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  cur_wrap;
    logic  cur_set;
    logic  cur_zero;
    logic  cur_adv;
    logic  out_load;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       pix_oob;
    logic       rd_oob;
    logic       page_oob;
    logic       need_wrap;
    logic       wrap_oob;
    logic       glyph_last;
    logic       sweep_last;
  } sts_t;

  function automatic logic [5:0] glyph_slot(input logic [7:0] code);
    logic [7:0] up;
    up = code;
    if (code == 8'h2E) return GLYPH_PERIOD;
    if (code == 8'h2D) return GLYPH_HYPHEN;
    if (code >= 8'h30 && code <= 8'h39) return GLYPH_DIGIT0 + 6'(code - 8'h30);
    if (code >= 8'h61 && code <= 8'h7A) up = code - 8'h20;
    if (up >= 8'h41 && up <= 8'h5A) return GLYPH_LETTER + 6'(up - 8'h41);
    return GLYPH_SPACE;
  endfunction

  function automatic logic [7:0] font_col(input logic [5:0] slot, input logic [2:0] k);
    logic [39:0] g;
    g = FONT[slot];
    return g[{k, 3'b000} +: 8];
  endfunction

endpackage

// ===== sv/gfr_ram.sv =====
module gfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gfr_datapath.sv =====
module gfr_datapath #(
  parameter int unsigned DISPLAY_WIDTH  = 128,
  parameter int unsigned DISPLAY_HEIGHT = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [2:0]    cmd_i,
  input  logic [7:0]    column_i,
  input  logic [7:0]    row_i,
  input  logic          pixel_on_i,
  input  logic [7:0]    page_index_i,
  input  logic [7:0]    character_i,
  input  gfr_pkg::ctl_t ctl_i,
  output gfr_pkg::sts_t sts_o,
  output logic [7:0]    read_data_o,
  output logic [7:0]    cursor_column_o,
  output logic [7:0]    cursor_row_o,
  output logic          ignored_o
);

  import gfr_pkg::*;

  localparam int unsigned TEXT_PAGES  = DISPLAY_HEIGHT / 8;
  localparam int unsigned PIXEL_PAGES = (DISPLAY_HEIGHT + 7) / 8;
  localparam int unsigned SWEEP_LEN   = PIXEL_PAGES * DISPLAY_WIDTH;

  logic [2:0]        cmd_q;
  logic [7:0]        column_q, row_q, page_q, char_q;
  logic              pixel_on_q, ign_q;
  logic [7:0]        text_col_q, text_col_d, text_page_q, text_page_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [7:0]        rd_data_q, cur_col_q, cur_row_q;
  logic              ignored_q;

  logic [ADDR_W-1:0] pix_addr, rd_addr, glyph_addr, waddr;
  logic [7:0]        mask, wdata, rdata, glyph_byte;

  assign pix_addr   = ADDR_W'(row_q[7:3]) * ADDR_W'(DISPLAY_WIDTH) + ADDR_W'(column_q);
  assign rd_addr    = ADDR_W'(page_q) * ADDR_W'(DISPLAY_WIDTH) + ADDR_W'(column_q);
  assign glyph_addr = ADDR_W'(text_page_q) * ADDR_W'(DISPLAY_WIDTH)
                      + ADDR_W'(text_col_q) + cnt_q;
  assign mask       = 8'b1 << row_q[2:0];
  assign glyph_byte = sts_o.glyph_last ? 8'h00 : font_col(glyph_slot(char_q), cnt_q[2:0]);

  always_comb begin
    case (ctl_i.wsel)
      WSEL_PIXEL: begin
        waddr = pix_addr;
        wdata = pixel_on_q ? (rdata | mask) : (rdata & ~mask);
      end
      WSEL_GLYPH: begin
        waddr = glyph_addr;
        wdata = glyph_byte;
      end
      WSEL_CLEAR: begin
        waddr = cnt_q;
        wdata = 8'h00;
      end
      default: begin
        waddr = cnt_q;
        wdata = 8'h00;
      end
    endcase
  end

  gfr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctl_i.rd_en),
    .raddr_i ((cmd_q == CMD_PIXEL) ? pix_addr : rd_addr),
    .rdata_o (rdata)
  );

  assign sts_o.cmd        = cmd_q;
  assign sts_o.pix_oob    = ({1'b0, column_q} >= 9'(DISPLAY_WIDTH))
                            || ({1'b0, row_q} >= 9'(DISPLAY_HEIGHT));
  assign sts_o.rd_oob     = ({1'b0, column_q} >= 9'(DISPLAY_WIDTH))
                            || ({1'b0, page_q} >= 9'(PIXEL_PAGES));
  assign sts_o.page_oob   = {1'b0, text_page_q} >= 9'(TEXT_PAGES);
  assign sts_o.need_wrap  = ({1'b0, text_col_q} + 9'(GLYPH_COLS)) >= 9'(DISPLAY_WIDTH);
  assign sts_o.wrap_oob   = ({1'b0, text_page_q} + 9'd1) >= 9'(TEXT_PAGES);
  assign sts_o.glyph_last = cnt_q == ADDR_W'(GLYPH_COLS);
  assign sts_o.sweep_last = cnt_q == ADDR_W'(SWEEP_LEN - 1);

  always_comb begin
    text_col_d  = text_col_q;
    text_page_d = text_page_q;
    if (ctl_i.cur_zero) begin
      text_col_d  = '0;
      text_page_d = '0;
    end else if (ctl_i.cur_set) begin
      text_col_d  = column_q;
      text_page_d = page_q;
    end else if (ctl_i.cur_wrap) begin
      text_col_d  = '0;
      text_page_d = text_page_q + 8'd1;
    end else if (ctl_i.cur_adv) begin
      text_col_d  = text_col_q + 8'(GLYPH_PITCH);
    end

    cnt_d = cnt_q;
    if (ctl_i.cnt_clr) begin
      cnt_d = '0;
    end else if (ctl_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_col_q  <= '0;
      text_page_q <= '0;
      cnt_q       <= '0;
    end else begin
      text_col_q  <= text_col_d;
      text_page_q <= text_page_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q      <= cmd_i;
      column_q   <= column_i;
      row_q      <= row_i;
      pixel_on_q <= pixel_on_i;
      page_q     <= page_index_i;
      char_q     <= character_i;
    end
    if (ctl_i.load) begin
      ign_q <= 1'b0;
    end else if (ctl_i.set_ign) begin
      ign_q <= 1'b1;
    end
    if (ctl_i.out_load) begin
      rd_data_q <= (cmd_q == CMD_READ && !ign_q) ? rdata : 8'h00;
      cur_col_q <= text_col_q;
      cur_row_q <= text_page_q;
      ignored_q <= ign_q;
    end
  end

  assign read_data_o     = rd_data_q;
  assign cursor_column_o = cur_col_q;
  assign cursor_row_o    = cur_row_q;
  assign ignored_o       = ignored_q;

endmodule

// ===== sv/gfr_ctrl.sv =====
module gfr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  gfr_pkg::sts_t sts_i,
  output gfr_pkg::ctl_t ctl_o
);

  import gfr_pkg::*;

  localparam logic [2:0] S_BOOT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_PIXWR  = 3'd3;
  localparam logic [2:0] S_GLYPH  = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_BOOT: begin
        ctl_o.wr_en   = 1'b1;
        ctl_o.wsel    = WSEL_CLEAR;
        ctl_o.cnt_inc = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        unique case (sts_i.cmd)
          CMD_PIXEL: begin
            if (sts_i.pix_oob) begin
              ctl_o.set_ign = 1'b1;
            end else begin
              ctl_o.rd_en = 1'b1;
              state_d     = S_PIXWR;
            end
          end
          CMD_CHAR: begin
            ctl_o.cnt_clr = 1'b1;
            if (sts_i.page_oob) begin
              ctl_o.set_ign = 1'b1;
            end else if (sts_i.need_wrap) begin
              ctl_o.cur_wrap = 1'b1;
              if (sts_i.wrap_oob) begin
                ctl_o.set_ign = 1'b1;
              end else begin
                state_d = S_GLYPH;
              end
            end else begin
              state_d = S_GLYPH;
            end
          end
          CMD_CURSOR: ctl_o.cur_set = 1'b1;
          CMD_CLEAR: begin
            ctl_o.cur_zero = 1'b1;
            ctl_o.cnt_clr  = 1'b1;
            state_d        = S_CLEAR;
          end
          CMD_READ: begin
            if (sts_i.rd_oob) begin
              ctl_o.set_ign = 1'b1;
            end else begin
              ctl_o.rd_en = 1'b1;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_PIXWR: begin
        ctl_o.wr_en = 1'b1;
        ctl_o.wsel  = WSEL_PIXEL;
        state_d     = S_DONE;
      end
      S_GLYPH: begin
        ctl_o.wr_en   = 1'b1;
        ctl_o.wsel    = WSEL_GLYPH;
        ctl_o.cnt_inc = 1'b1;
        if (sts_i.glyph_last) begin
          ctl_o.cur_adv = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_CLEAR: begin
        ctl_o.wr_en   = 1'b1;
        ctl_o.wsel    = WSEL_CLEAR;
        ctl_o.cnt_inc = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || ctl_o.out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_BOOT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/glyph_framebuffer_renderer.sv =====
// Channel    Dir  Request fields (lsb first)
// s_axis     in   tuser: cmd; tdata: column, row, pixel_on, page_index, character
// m_axis     out  tdata: read_data, cursor_column, cursor_row, ignored
//
// One request at a time. A pixel request reads its store byte and then writes it;
// a character makes six store writes through the single write port; clear zeroes
// ceil(DISPLAY_HEIGHT/8)*DISPLAY_WIDTH bytes; ignored requests write nothing.
// After reset the store is swept to zero, ceil(DISPLAY_HEIGHT/8)*DISPLAY_WIDTH bytes
// (1024 at default size), with s_axis_tready low.
// A result waits in the output register; the next request is taken meanwhile and
// holds in its last cycle only if the previous result is still not taken.
module glyph_framebuffer_renderer #(
  parameter int unsigned DISPLAY_WIDTH  = 128,
  parameter int unsigned DISPLAY_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // column, row, pixel_on, page_index, character
  input  logic [2:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // read_data, cursor_column, cursor_row, ignored
);

  import gfr_pkg::*;

  ctl_t       ctl;
  sts_t       sts;
  logic [7:0] read_data, cursor_column, cursor_row;
  logic       ignored;

  gfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  gfr_datapath #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (s_axis_tuser),
    .column_i        (s_axis_tdata[7:0]),
    .row_i           (s_axis_tdata[15:8]),
    .pixel_on_i      (s_axis_tdata[16]),
    .page_index_i    (s_axis_tdata[24:17]),
    .character_i     (s_axis_tdata[32:25]),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .read_data_o     (read_data),
    .cursor_column_o (cursor_column),
    .cursor_row_o    (cursor_row),
    .ignored_o       (ignored)
  );

  assign m_axis_tdata = {7'b0, ignored, cursor_row, cursor_column, read_data};

endmodule

// ===== tb/glyph_framebuffer_renderer_tb.sv =====
module glyph_framebuffer_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gfr_pkg::*;

  localparam int unsigned DISP_W     = 128;
  localparam int unsigned DISP_H     = 64;
  localparam int unsigned TEXT_PAGES = DISP_H / 8;
  localparam int unsigned PIX_PAGES  = (DISP_H + 7) / 8;
  localparam int unsigned FB_BYTES   = 1024;
  localparam int unsigned MAX_CYCLES = 400000;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // slot 0 space, 1..10 digits, 11..36 letters, 37 dot, 38 minus
  localparam logic [7:0] GLYPHS [39][5] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
    '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
    '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}
  };

  // request fields, lowest bit last in the list
  typedef struct packed {
    logic [7:0] chr;
    logic [7:0] page;
    logic       on;
    logic [7:0] row;
    logic [7:0] col;
  } request_t;

  typedef struct packed {
    logic       ign;
    logic [7:0] crow;
    logic [7:0] ccol;
    logic [7:0] rdata;
  } screen_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  logic [7:0]    shadow_fb [FB_BYTES];
  logic [7:0]    shadow_col;
  logic [7:0]    shadow_page;
  screen_reply_t reply_q [$];
  screen_reply_t reply_want;
  screen_reply_t reply_got;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  logic        sink_hold = 1'b0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  glyph_framebuffer_renderer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic int unsigned fb_addr(input int unsigned pg, input int unsigned c);
    return (pg * DISP_W + c) % FB_BYTES;
  endfunction

  function automatic int unsigned font_slot(input logic [7:0] code);
    logic [7:0] up;
    up = (code >= "a" && code <= "z") ? code - 8'd32 : code;
    case (1'b1)
      code == ".":                return 37;
      code == "-":                return 38;
      code >= "0" && code <= "9": return 1 + int'(code - "0");
      up >= "A" && up <= "Z":     return 11 + int'(up - "A");
      default:                    return 0;
    endcase
  endfunction

  task automatic clear_shadow();
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    shadow_col  = '0;
    shadow_page = '0;
  endtask

  // advances the shadow screen by one request and gives the reply it should produce
  task automatic render_request(input logic [2:0] cmd, input request_t r,
                                output screen_reply_t rep);
    int unsigned a;
    int unsigned slot;
    logic [7:0]  mask;
    rep = '0;
    case (cmd)
      CMD_PIXEL: begin
        if (r.col >= DISP_W || r.row >= DISP_H) begin
          rep.ign = 1'b1;
        end else begin
          a    = fb_addr(r.row >> 3, r.col);
          mask = 8'(1 << r.row[2:0]);
          shadow_fb[a] = r.on ? (shadow_fb[a] | mask) : (shadow_fb[a] & ~mask);
        end
      end
      CMD_CHAR: begin
        if (shadow_page >= TEXT_PAGES) begin
          rep.ign = 1'b1;
        end else begin
          if (int'(shadow_col) + 5 >= DISP_W) begin
            shadow_col  = '0;
            shadow_page = shadow_page + 8'd1;
          end
          if (shadow_page >= TEXT_PAGES) begin
            rep.ign = 1'b1;
          end else begin
            slot = font_slot(r.chr);
            for (int k = 0; k < 5; k++)
              shadow_fb[fb_addr(shadow_page, shadow_col + k)] = GLYPHS[slot][k];
            shadow_fb[fb_addr(shadow_page, shadow_col + 5)] = '0;
            shadow_col = shadow_col + 8'd6;
          end
        end
      end
      CMD_CURSOR: begin
        shadow_col  = r.col;
        shadow_page = r.page;
      end
      CMD_CLEAR: clear_shadow();
      CMD_READ: begin
        if (r.col >= DISP_W || r.page >= PIX_PAGES) rep.ign = 1'b1;
        else rep.rdata = shadow_fb[fb_addr(r.page, r.col)];
      end
      default: ;
    endcase
    rep.ccol = shadow_col;
    rep.crow = shadow_page;
  endtask

  function automatic request_t mk_req(input logic [7:0] col, input logic [7:0] row,
                                      input logic on, input logic [7:0] page,
                                      input logic [7:0] chr);
    request_t r;
    r.col  = col;
    r.row  = row;
    r.on   = on;
    r.page = page;
    r.chr  = chr;
    return r;
  endfunction

  // called at a rising edge; returns at the edge the request was taken
  task automatic send_request(input logic [2:0] cmd, input request_t r);
    screen_reply_t rep;
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, r};
    do @(posedge clk_i); while (!s_axis_tready);
    render_request(cmd, r, rep);
    reply_q.push_back(rep);
  endtask

  task automatic random_request(output logic [2:0] cmd, output request_t r);
    string       glyph_set;
    int unsigned pick;
    glyph_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz.- ";
    r    = request_t'({$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 35) begin
      cmd = CMD_CHAR;
      if ($urandom_range(9) < 8) r.chr = glyph_set[$urandom_range(glyph_set.len() - 1)];
    end else if (pick < 60) begin
      cmd = CMD_PIXEL;
      if ($urandom_range(9) != 0) r.col = 8'($urandom_range(DISP_W - 1));
      if ($urandom_range(9) != 0) r.row = 8'($urandom_range(DISP_H - 1));
    end else if (pick < 80) begin
      cmd = CMD_READ;
      if ($urandom_range(9) != 0) begin
        r.col  = 8'($urandom_range(DISP_W - 1));
        r.page = 8'($urandom_range(PIX_PAGES - 1));
      end
    end else if (pick < 93) begin
      cmd = CMD_CURSOR;
      if ($urandom_range(9) != 0) begin
        r.col  = ($urandom_range(2) == 0) ? 8'($urandom_range(DISP_W - 1, DISP_W - 20))
                                          : 8'($urandom_range(DISP_W - 1));
        r.page = 8'($urandom_range(TEXT_PAGES - 1));
      end
    end else if (pick < 94) begin
      cmd = CMD_CLEAR;
    end else begin
      cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      reply_got = m_axis_tdata[24:0];
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none actual %h",
                 $time, m_axis_tdata);
      end else begin
        reply_want = reply_q.pop_front();
        check_field("read_data", reply_want.rdata, reply_got.rdata);
        check_field("cursor_column", reply_want.ccol, reply_got.ccol);
        check_field("cursor_row", reply_want.crow, reply_got.crow);
        check_field("ignored", 8'(reply_want.ign), 8'(reply_got.ign));
      end
    end
  end

  task automatic test_pixels();
    send_request(CMD_PIXEL, mk_req(8'd0, 8'd0, 1'b1, 8'h00, 8'h00));
    send_request(CMD_PIXEL, mk_req(8'd127, 8'd63, 1'b1, 8'hFF, 8'hFF));
    send_request(CMD_PIXEL, mk_req(8'd128, 8'd0, 1'b1, 8'h00, 8'h00));
    send_request(CMD_PIXEL, mk_req(8'd0, 8'd64, 1'b1, 8'h00, 8'h00));
    send_request(CMD_READ, mk_req(8'd0, 8'd0, 1'b0, 8'd0, 8'h00));
    send_request(CMD_READ, mk_req(8'd127, 8'd0, 1'b0, 8'd7, 8'h00));
    send_request(CMD_PIXEL, mk_req(8'd0, 8'd0, 1'b0, 8'h00, 8'h00));
  endtask

  task automatic test_text();
    send_request(CMD_CHAR, mk_req(8'h00, 8'h00, 1'b0, 8'h00, "A"));
    send_request(CMD_CHAR, mk_req(8'h00, 8'h00, 1'b0, 8'h00, "z"));
    send_request(CMD_CHAR, mk_req(8'h00, 8'h00, 1'b0, 8'h00, "9"));
    send_request(CMD_CHAR, mk_req(8'h00, 8'h00, 1'b0, 8'h00, "."));
    send_request(CMD_CHAR, mk_req(8'h00, 8'h00, 1'b0, 8'h00, "-"));
    send_request(CMD_CHAR, mk_req(8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF));
  endtask

  task automatic test_cursor_edges();
    // wrap onto the next page, then wrap off the bottom
    send_request(CMD_CURSOR, mk_req(8'd123, 8'h00, 1'b0, 8'd0, 8'h00));
    send_request(CMD_CHAR, mk_req(8'h00, 8'h00, 1'b0, 8'h00, "M"));
    send_request(CMD_CURSOR, mk_req(8'd255, 8'hFF, 1'b1, 8'd7, 8'hFF));
    send_request(CMD_CHAR, mk_req(8'h00, 8'h00, 1'b0, 8'h00, "Q"));
    send_request(CMD_CHAR, mk_req(8'h00, 8'h00, 1'b0, 8'h00, "0"));
  endtask

  task automatic test_misc_commands();
    send_request(CMD_READ, mk_req(8'd128, 8'h00, 1'b0, 8'd0, 8'h00));
    send_request(CMD_READ, mk_req(8'd255, 8'hFF, 1'b1, 8'd255, 8'hFF));
    send_request(CMD_SPARE_HI, mk_req(8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF));
    send_request(CMD_CLEAR, mk_req(8'h00, 8'h00, 1'b0, 8'h00, 8'h00));
    send_request(CMD_READ, mk_req(8'd1, 8'h00, 1'b0, 8'd1, 8'h00));
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned src_pct,
                                     input int unsigned sink_pct);
    logic [2:0] cmd;
    request_t   r;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (count) begin
      random_request(cmd, r);
      send_request(cmd, r);
    end
  endtask

  task automatic test_output_stall();
    logic [2:0] cmd;
    request_t   r;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (300) @(posedge clk_i);
        sink_hold <= 1'b0;
      end
      repeat (60) begin
        random_request(cmd, r);
        send_request(cmd, r);
      end
    join
  endtask

  initial begin
    clear_shadow();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pixels();
    test_text();
    test_cursor_edges();
    test_misc_commands();
    test_random_traffic(400, 0, 0);
    test_random_traffic(400, 53, 0);
    test_random_traffic(400, 0, 53);
    test_output_stall();
    test_random_traffic(400, 34, 34);

    s_axis_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/gfr_pkg.sv
sv/gfr_ram.sv
sv/gfr_datapath.sv
sv/gfr_ctrl.sv
sv/glyph_framebuffer_renderer.sv
tb/glyph_framebuffer_renderer_tb.sv
